[rtl/bfsa_pkg.sv]
// ----------------------------------------------------------------------------
// bfsa_pkg
// shared types and constants of the best-fit segment allocator
// ----------------------------------------------------------------------------
package bfsa_pkg;

  localparam int MAX_SEG = 16;
  localparam int IDX_W   = $clog2(MAX_SEG);
  localparam int CNT_W   = IDX_W + 1;
  localparam int ADDR_W  = 16;

  localparam logic [ADDR_W-1:0] ADDR_LIMIT = '1;
  localparam logic [ADDR_W-1:0] HEAP_RESET = 16'hFFFF;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_REALLOC = 2'd1,
    OP_FREE    = 2'd2,
    OP_REINIT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_NO_FIT = 2'd1,
    STS_FULL   = 2'd2
  } status_e;

  // read request into the segment table
  typedef struct packed {
    logic bank;
    idx_t idx;
  } tab_rd_t;

  // write request into the segment table
  typedef struct packed {
    logic  en;
    logic  bank;
    idx_t  idx;
    addr_t seg_start;
    addr_t seg_end;
  } tab_wr_t;

endpackage

[rtl/bfsa_table.sv]
// ----------------------------------------------------------------------------
// bfsa_table
// two banks of free segments (start, end), one read and one write port
// ----------------------------------------------------------------------------
module bfsa_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bfsa_pkg::tab_rd_t rd_i,
  input  bfsa_pkg::tab_wr_t wr_i,
  output bfsa_pkg::addr_t  rd_start_o,
  output bfsa_pkg::addr_t  rd_end_o
);
  import bfsa_pkg::*;

  addr_t seg_start_q [2][MAX_SEG];
  addr_t seg_end_q   [2][MAX_SEG];
  logic  init_q;

  // segment storage
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      seg_start_q[wr_i.bank][wr_i.idx] <= wr_i.seg_start;
      seg_end_q[wr_i.bank][wr_i.idx]   <= wr_i.seg_end;
    end
  end

  // after reset bank 0 entry 0 reads as the full heap until written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b1;
    end else if (wr_i.en && !wr_i.bank && wr_i.idx == '0) begin
      init_q <= 1'b0;
    end
  end

  // read port
  always_comb begin
    if (init_q && !rd_i.bank && rd_i.idx == '0) begin
      rd_start_o = '0;
      rd_end_o   = HEAP_RESET;
    end else begin
      rd_start_o = seg_start_q[rd_i.bank][rd_i.idx];
      rd_end_o   = seg_end_q[rd_i.bank][rd_i.idx];
    end
  end

endmodule

[rtl/best_fit_segment_allocator.sv]
// ----------------------------------------------------------------------------
// best_fit_segment_allocator
// best-fit free list allocator with coalescing over a 16-entry segment table
// ----------------------------------------------------------------------------
// passes: a scan pass steps through the segments held, a merge pass through them
// and the segment to insert; a reallocate that moves its block runs scan,
// merge, scan and merge passes.
// a new request is taken only while idle, the next may start in the result cycle.
// the result beat is shown for one cycle on done_o, busy is low meanwhile.
// reset: one free segment 0..65535, heap_size 65535, block idle.
module best_fit_segment_allocator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           operation_i,
  input  bfsa_pkg::addr_t      block_address_i,
  input  bfsa_pkg::addr_t      block_length_i,
  input  bfsa_pkg::addr_t      new_length_i,
  input  logic                 heap_size_we_i,
  input  bfsa_pkg::addr_t      heap_size_i,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output bfsa_pkg::addr_t      granted_address_o,
  output bfsa_pkg::cnt_t       free_segments_o
);
  import bfsa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MERGE
  } state_e;

  state_e  state_q;
  logic    bank_q;
  cnt_t    cnt_q;
  addr_t   heap_q;

  // request
  addr_t   a_q, len_q, nl_q;
  logic [ADDR_W:0] sum_al_q, sum_anl_q;
  logic    grow_mode_q, move_q;

  // pass control
  logic    src_bank_q;
  cnt_t    src_n_q, src_i_q, w_q;
  logic    found_q;
  idx_t    best_idx_q;
  addr_t   best_s_q, best_rem_q;
  logic    mod_en_q;
  idx_t    mod_idx_q;
  addr_t   mod_s_q;
  logic    ins_pend_q;
  addr_t   ins_s_q, ins_e_q;
  logic    have_cur_q;
  addr_t   cur_s_q, cur_e_q;
  addr_t   granted_q;

  // result beat
  logic    done_q;
  status_e status_q;
  addr_t   res_addr_q;
  cnt_t    free_q;

  tab_rd_t rd;
  tab_wr_t wr;
  addr_t   rd_start, rd_end;

  function automatic addr_t clip(input logic [ADDR_W:0] v);
    if (v > {1'b0, ADDR_LIMIT}) begin
      return ADDR_LIMIT;
    end
    return v[ADDR_W-1:0];
  endfunction

  bfsa_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_i       (rd),
    .wr_i       (wr),
    .rd_start_o (rd_start),
    .rd_end_o   (rd_end)
  );

  // input sums
  logic [ADDR_W:0] in_al, in_anl;
  assign in_al  = {1'b0, block_address_i} + {1'b0, block_length_i};
  assign in_anl = {1'b0, block_address_i} + {1'b0, new_length_i};

  // shared compare unit on the entry under the read pointer
  addr_t seg_size, rem, ent_s, item_s, item_e;
  logic  take, grow_hit, src_left, use_ins, item_vld, item_live, merge_hit, flush_wr;
  cnt_t  fin_cnt;

  assign rd       = '{bank: src_bank_q, idx: src_i_q[IDX_W-1:0]};
  assign seg_size = rd_end - rd_start;
  assign rem      = seg_size - len_q;
  assign take     = (seg_size >= len_q) && (!found_q || rem < best_rem_q);
  assign grow_hit = ({1'b0, rd_start} == sum_al_q) && (sum_anl_q <= {1'b0, rd_end});

  assign src_left = src_i_q < src_n_q;
  assign ent_s    = (mod_en_q && src_i_q[IDX_W-1:0] == mod_idx_q) ? mod_s_q : rd_start;
  assign use_ins  = ins_pend_q && (!src_left || ent_s >= ins_s_q);
  assign item_vld = use_ins || src_left;
  assign item_s   = use_ins ? ins_s_q : ent_s;
  assign item_e   = use_ins ? ins_e_q : rd_end;
  assign item_live = item_e > item_s;
  assign merge_hit = have_cur_q && cur_e_q >= item_s;
  assign fin_cnt  = w_q + cnt_t'(have_cur_q);

  // write the finished segment when a new one opens or the pass ends
  assign flush_wr = (state_q == ST_MERGE) && have_cur_q &&
                    ((item_vld && item_live && !merge_hit) || !item_vld) &&
                    (w_q < cnt_t'(MAX_SEG));
  assign wr = '{en: flush_wr, bank: ~src_bank_q, idx: w_q[IDX_W-1:0],
                seg_start: cur_s_q, seg_end: cur_e_q};

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bank_q      <= 1'b0;
      cnt_q       <= cnt_t'(1);
      heap_q      <= HEAP_RESET;
      done_q      <= 1'b0;
      status_q    <= STS_OK;
      res_addr_q  <= '0;
      free_q      <= '0;
      move_q      <= 1'b0;
      grow_mode_q <= 1'b0;
      found_q     <= 1'b0;
      mod_en_q    <= 1'b0;
      ins_pend_q  <= 1'b0;
      have_cur_q  <= 1'b0;
      src_bank_q  <= 1'b0;
      src_n_q     <= '0;
      src_i_q     <= '0;
      w_q         <= '0;
    end else begin
      done_q <= 1'b0;
      if (heap_size_we_i) begin
        heap_q <= heap_size_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            a_q         <= block_address_i;
            nl_q        <= new_length_i;
            sum_al_q    <= in_al;
            sum_anl_q   <= in_anl;
            move_q      <= 1'b0;
            mod_en_q    <= 1'b0;
            ins_pend_q  <= 1'b0;
            have_cur_q  <= 1'b0;
            found_q     <= 1'b0;
            src_bank_q  <= bank_q;
            src_n_q     <= cnt_q;
            src_i_q     <= '0;
            w_q         <= '0;
            granted_q   <= '0;
            len_q       <= block_length_i;
            grow_mode_q <= 1'b0;
            case (op_e'(operation_i))
              OP_ALLOC: begin
                state_q <= ST_SCAN;
              end
              OP_REALLOC: begin
                if (new_length_i < block_length_i) begin
                  ins_s_q    <= clip(in_anl);
                  ins_e_q    <= clip(in_al);
                  ins_pend_q <= clip(in_al) > clip(in_anl);
                  granted_q  <= block_address_i;
                  state_q    <= ST_MERGE;
                end else begin
                  grow_mode_q <= 1'b1;
                  state_q     <= ST_SCAN;
                end
              end
              OP_FREE: begin
                ins_s_q    <= block_address_i;
                ins_e_q    <= clip(in_al);
                ins_pend_q <= clip(in_al) > block_address_i;
                state_q    <= ST_MERGE;
              end
              OP_REINIT: begin
                ins_s_q    <= '0;
                ins_e_q    <= heap_q;
                ins_pend_q <= heap_q != '0;
                src_n_q    <= '0;
                state_q    <= ST_MERGE;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end

        ST_SCAN: begin
          if (src_left) begin
            // one entry per cycle through the fit or grow compare
            if (!grow_mode_q && take) begin
              found_q    <= 1'b1;
              best_idx_q <= src_i_q[IDX_W-1:0];
              best_s_q   <= rd_start;
              best_rem_q <= rem;
            end else if (grow_mode_q && grow_hit) begin
              found_q    <= 1'b1;
              best_idx_q <= src_i_q[IDX_W-1:0];
            end
            src_i_q <= src_i_q + cnt_t'(1);
          end else begin
            src_i_q    <= '0;
            w_q        <= '0;
            have_cur_q <= 1'b0;
            if (!grow_mode_q) begin
              if (found_q) begin
                mod_en_q  <= 1'b1;
                mod_idx_q <= best_idx_q;
                mod_s_q   <= best_s_q + len_q;
                granted_q <= best_s_q;
                state_q   <= ST_MERGE;
              end else begin
                done_q     <= 1'b1;
                status_q   <= STS_NO_FIT;
                res_addr_q <= '0;
                free_q     <= cnt_q;
                state_q    <= ST_IDLE;
              end
            end else if (found_q) begin
              mod_en_q  <= 1'b1;
              mod_idx_q <= best_idx_q;
              mod_s_q   <= sum_anl_q[ADDR_W-1:0];
              granted_q <= a_q;
              state_q   <= ST_MERGE;
            end else begin
              // grow by moving: free the block first
              ins_s_q    <= a_q;
              ins_e_q    <= clip(sum_al_q);
              ins_pend_q <= clip(sum_al_q) > a_q;
              move_q     <= 1'b1;
              state_q    <= ST_MERGE;
            end
          end
        end

        ST_MERGE: begin
          if (item_vld) begin
            // sorted stream with drop of empty and merge of touching segments
            if (use_ins) begin
              ins_pend_q <= 1'b0;
            end else begin
              src_i_q <= src_i_q + cnt_t'(1);
            end
            if (item_live) begin
              if (merge_hit) begin
                if (item_e > cur_e_q) begin
                  cur_e_q <= item_e;
                end
              end else begin
                if (have_cur_q) begin
                  w_q <= w_q + cnt_t'(1);
                end
                cur_s_q    <= item_s;
                cur_e_q    <= item_e;
                have_cur_q <= 1'b1;
              end
            end
          end else begin
            // end of pass
            if (fin_cnt > cnt_t'(MAX_SEG)) begin
              done_q     <= 1'b1;
              status_q   <= STS_FULL;
              res_addr_q <= '0;
              free_q     <= cnt_q;
              state_q    <= ST_IDLE;
            end else if (move_q) begin
              move_q      <= 1'b0;
              grow_mode_q <= 1'b0;
              len_q       <= nl_q;
              found_q     <= 1'b0;
              mod_en_q    <= 1'b0;
              src_bank_q  <= ~src_bank_q;
              src_n_q     <= fin_cnt;
              src_i_q     <= '0;
              state_q     <= ST_SCAN;
            end else begin
              bank_q     <= ~src_bank_q;
              cnt_q      <= fin_cnt;
              done_q     <= 1'b1;
              status_q   <= STS_OK;
              res_addr_q <= granted_q;
              free_q     <= fin_cnt;
              state_q    <= ST_IDLE;
            end
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy              = state_q != ST_IDLE;
  assign done_o            = done_q;
  assign status_o          = status_q;
  assign granted_address_o = res_addr_q;
  assign free_segments_o   = free_q;

  // checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cnt_t'(MAX_SEG))
    else $error("segment count beyond table depth");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ST_IDLE)
    else $error("result beat while a pass is running");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not start the sequencer");

  a_merge_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MERGE |-> src_i_q <= src_n_q)
    else $error("merge read pointer ran past the source table");

  a_fail_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q != STS_OK) |-> (free_q == cnt_q && res_addr_q == '0))
    else $error("failed request changed the table or granted an address");

endmodule
